// File: rtl/gamepad_deadzone_edge_conditioner_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gamepad deadzone conditioner
// Concurrent checks that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_DEADZONE_EDGE_CONDITIONER_CORE_MACROS_SVH
`define GAMEPAD_DEADZONE_EDGE_CONDITIONER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GDEC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("gdec check failed");
// antecedent implies consequent in the next cycle
`define GDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("gdec check failed");
`else
`define GDEC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/gdec_pkg.sv
// ---------------------------------------------------------------------------
// gdec_pkg
// Shared constants and divider request/response types.
// ---------------------------------------------------------------------------
`default_nettype none

package gdec_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int DVD_W     = 31;
    localparam int DVS_W     = 15;
    localparam int QUO_W     = 16;

    localparam logic [14:0] FULL_SCALE  = 15'd32767;
    localparam logic [7:0]  TRIG_RANGE  = 8'd255;

    localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
    localparam logic [7:0]  TRIG_THR_RST = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_DZ  = 2'd0,
        CFG_RIGHT_DZ = 2'd1,
        CFG_TRIG_THR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [14:0]        quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: rtl/gdec_div.sv
// ---------------------------------------------------------------------------
// gdec_div
// Restoring divider, one quotient bit per cycle, saturated at 32767.
// ---------------------------------------------------------------------------
`default_nettype none

module gdec_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gdec_pkg::t_div_req i_req,
    output gdec_pkg::t_div_rsp      o_rsp
);
    import gdec_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [DVS_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_q;
    logic              r_ovf;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign trial = {r_rem, r_low[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
                r_rem  <= i_req.dividend[DVD_W-1:QUO_W];
                r_low  <= i_req.dividend[QUO_W-1:0];
                r_dvs  <= i_req.divisor;
                // quotient of 2^16 or more: saturate (covers a zero divisor)
                r_ovf  <= i_req.dividend[DVD_W-1:QUO_W] >= i_req.divisor;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_low <= {r_low[QUO_W-2:0], 1'b0};
                r_q   <= {r_q[QUO_W-2:0], fits};
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_ovf || r_q[QUO_W-1]) ? FULL_SCALE : r_q[14:0];

endmodule

`default_nettype wire

// File: rtl/gamepad_deadzone_edge_conditioner_core.sv
// ---------------------------------------------------------------------------
// gamepad_deadzone_edge_conditioner_core
// Rescales triggers and stick axes past their deadzones and reports
// button press and release edges for one pad poll per item.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  poll in  | i_in_valid / o_in_stall    | connected, buttons, triggers, sticks
//  result   | o_out_valid / i_out_stall  | connected, button masks, norms
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  A connected poll runs six values through one shared 16-step divider:
//  a value past its deadzone goes through S_LOAD and then S_WAIT, a value
//  inside it is set to zero in S_LOAD. A disconnected poll skips to S_DONE.
//  Reset (synchronous, active low) clears the stored mask and loads the
//  default deadzones. The next poll is taken while a result waits; a
//  stalled result holds the finished poll in its last state.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gamepad_deadzone_edge_conditioner_core_macros.svh"

module gamepad_deadzone_edge_conditioner_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_cfg_we,
    input  wire logic [gdec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [14:0]                     i_cfg_data,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_connected_in,
    input  wire logic [15:0]                     i_buttons_raw,
    input  wire logic [7:0]                      i_trigger_left_raw,
    input  wire logic [7:0]                      i_trigger_right_raw,
    input  wire logic signed [15:0]              i_stick_left_x,
    input  wire logic signed [15:0]              i_stick_left_y,
    input  wire logic signed [15:0]              i_stick_right_x,
    input  wire logic signed [15:0]              i_stick_right_y,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_connected_out,
    output logic [17:0]                          o_buttons_held,
    output logic [17:0]                          o_buttons_pressed,
    output logic [17:0]                          o_buttons_released,
    output logic [14:0]                          o_trigger_left_norm,
    output logic [14:0]                          o_trigger_right_norm,
    output logic signed [15:0]                   o_left_x_norm,
    output logic signed [15:0]                   o_left_y_norm,
    output logic signed [15:0]                   o_right_x_norm,
    output logic signed [15:0]                   o_right_y_norm
);
    import gdec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_TRIG_L  = 3'd0,
        OP_TRIG_R  = 3'd1,
        OP_AXIS_LX = 3'd2,
        OP_AXIS_LY = 3'd3,
        OP_AXIS_RX = 3'd4,
        OP_AXIS_RY = 3'd5
    } t_op;

    t_state       r_state;
    t_op          r_op;
    logic [14:0]  r_left_dz;
    logic [14:0]  r_right_dz;
    logic [7:0]   r_thr;
    logic [17:0]  r_prev;
    logic         r_conn;
    logic [15:0]  r_btn;
    logic [15:0]  r_src [6];
    logic [15:0]  r_val [6];
    logic         r_neg;
    logic         r_out_valid;

    t_div_req     div_req;
    t_div_rsp     div_rsp;

    logic         op_trig;
    logic [15:0]  src;
    logic [14:0]  dz;
    logic         neg;
    logic [15:0]  mag;
    logic         gt;
    logic [15:0]  num;
    logic [14:0]  den;
    logic [15:0]  signed_q;
    logic [17:0]  n_now;

    gdec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // operand setup for the value selected by r_op
    always_comb begin
        op_trig = (r_op == OP_TRIG_L) || (r_op == OP_TRIG_R);
        src     = r_src[r_op];
        dz      = ((r_op == OP_AXIS_LX) || (r_op == OP_AXIS_LY)) ? r_left_dz : r_right_dz;
        if (op_trig) begin
            neg = 1'b0;
            mag = src;
            gt  = src[7:0] > r_thr;
            num = {8'd0, 8'(src[7:0] - r_thr)};
            den = {7'd0, 8'(TRIG_RANGE - r_thr)};
        end else begin
            neg = src[15];
            mag = neg ? 16'(~src + 16'd1) : src;
            gt  = mag > {1'b0, dz};
            num = 16'(mag - {1'b0, dz});
            den = 15'(FULL_SCALE - dz);
        end
        // 32767 * num as (num << 15) - num
        div_req.dividend = {num, 15'd0} - {15'd0, num};
        div_req.divisor  = den;
        div_req.start    = (r_state == S_LOAD) && gt;
    end

    assign signed_q = r_neg ? 16'(-{1'b0, div_rsp.quot}) : {1'b0, div_rsp.quot};

    assign n_now = r_conn ? {(r_val[OP_TRIG_R] != 16'd0), (r_val[OP_TRIG_L] != 16'd0), r_btn}
                          : 18'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TRIG_L;
            r_left_dz   <= LEFT_DZ_RST;
            r_right_dz  <= RIGHT_DZ_RST;
            r_thr       <= TRIG_THR_RST;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LEFT_DZ:  r_left_dz  <= i_cfg_data;
                    CFG_RIGHT_DZ: r_right_dz <= i_cfg_data;
                    CFG_TRIG_THR: r_thr      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // in S_DONE a taken result is replaced by the next one below
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_conn   <= i_connected_in;
                        r_btn    <= i_buttons_raw;
                        r_src[0] <= {8'd0, i_trigger_left_raw};
                        r_src[1] <= {8'd0, i_trigger_right_raw};
                        r_src[2] <= i_stick_left_x;
                        r_src[3] <= i_stick_left_y;
                        r_src[4] <= i_stick_right_x;
                        r_src[5] <= i_stick_right_y;
                        r_op     <= OP_TRIG_L;
                        r_state  <= i_connected_in ? S_LOAD : S_DONE;
                    end
                end
                S_LOAD: begin
                    r_neg <= neg;
                    if (gt) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_val[r_op] <= 16'd0;
                        if (r_op == OP_AXIS_RY) begin
                            r_state <= S_DONE;
                        end else begin
                            r_op <= t_op'(r_op + 3'd1);
                        end
                    end
                end
                S_WAIT: begin
                    if (div_rsp.done) begin
                        r_val[r_op] <= signed_q;
                        if (r_op == OP_AXIS_RY) begin
                            r_state <= S_DONE;
                        end else begin
                            r_op    <= t_op'(r_op + 3'd1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || !i_out_stall) begin
                        o_connected_out      <= r_conn;
                        o_buttons_held       <= n_now;
                        o_buttons_pressed    <= n_now & ~r_prev;
                        o_buttons_released   <= r_conn ? (r_prev & ~n_now) : 18'd0;
                        o_trigger_left_norm  <= r_conn ? r_val[OP_TRIG_L][14:0] : 15'd0;
                        o_trigger_right_norm <= r_conn ? r_val[OP_TRIG_R][14:0] : 15'd0;
                        o_left_x_norm        <= r_conn ? r_val[OP_AXIS_LX] : 16'd0;
                        o_left_y_norm        <= r_conn ? r_val[OP_AXIS_LY] : 16'd0;
                        o_right_x_norm       <= r_conn ? r_val[OP_AXIS_RX] : 16'd0;
                        o_right_y_norm       <= r_conn ? r_val[OP_AXIS_RY] : 16'd0;
                        r_prev               <= n_now;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `GDEC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall)
    `GDEC_ASSERT_SAME(a_edges_disjoint, i_clk, i_rst_n, o_out_valid,
        (o_buttons_pressed & o_buttons_released) == 18'd0)
    `GDEC_ASSERT_SAME(a_disconnected_zero, i_clk, i_rst_n, o_out_valid && !o_connected_out,
        (o_buttons_held == 18'd0) && (o_buttons_released == 18'd0) &&
        (o_left_x_norm == 16'sd0))
    `GDEC_ASSERT_SAME(a_axis_no_min, i_clk, i_rst_n, o_out_valid,
        (o_left_x_norm != 16'sh8000) && (o_right_y_norm != 16'sh8000))

endmodule

`default_nettype wire

// File: tb/sv/gamepad_deadzone_edge_conditioner_core_checker.sv
// ---------------------------------------------------------------------------
// Poll result checker for the gamepad deadzone conditioner
// Watches the configuration port and both channels, predicts each result
// from the accepted poll and the register settings, and compares the
// results field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module gdec_poll_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [gdec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [14:0]                     i_cfg_data,

    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_connected_in,
    input  logic [15:0]                     i_buttons_raw,
    input  logic [7:0]                      i_trigger_left_raw,
    input  logic [7:0]                      i_trigger_right_raw,
    input  logic [15:0]                     i_stick_left_x,
    input  logic [15:0]                     i_stick_left_y,
    input  logic [15:0]                     i_stick_right_x,
    input  logic [15:0]                     i_stick_right_y,

    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_connected_out,
    input  logic [17:0]                     i_buttons_held,
    input  logic [17:0]                     i_buttons_pressed,
    input  logic [17:0]                     i_buttons_released,
    input  logic [14:0]                     i_trigger_left_norm,
    input  logic [14:0]                     i_trigger_right_norm,
    input  logic [15:0]                     i_left_x_norm,
    input  logic [15:0]                     i_left_y_norm,
    input  logic [15:0]                     i_right_x_norm,
    input  logic [15:0]                     i_right_y_norm,

    output int                              o_mismatch_count,
    output int                              o_pending
);
    import gdec_pkg::*;

    typedef struct packed {
        logic        connected;
        logic [17:0] held;
        logic [17:0] pressed;
        logic [17:0] released;
        logic [14:0] trig_l;
        logic [14:0] trig_r;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
    } t_pad_result;

    t_pad_result expected_results[$];

    logic [14:0] left_dz;
    logic [14:0] right_dz;
    logic [7:0]  trig_thr;
    logic [17:0] held_prev;

    int mismatches = 0;
    int waiting    = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending        = waiting;

    // floor(32767 * num / den), saturated; a zero divisor gives full scale
    function automatic logic [14:0] rescale_q15(int unsigned num, int unsigned den);
        longint unsigned q;
        if (den == 0) return FULL_SCALE;
        q = (longint'(FULL_SCALE) * num) / den;
        return (q > FULL_SCALE) ? FULL_SCALE : q[14:0];
    endfunction

    function automatic logic [15:0] stick_to_q15(logic [15:0] raw, logic [14:0] dz);
        int unsigned mag;
        int unsigned zone;
        logic [15:0] r;
        zone = dz;
        mag  = raw[15] ? (32'h10000 - raw) : raw;
        if (mag <= zone) return '0;
        r = {1'b0, rescale_q15(mag - zone, 32'd32767 - zone)};
        return raw[15] ? (16'h0000 - r) : r;
    endfunction

    function automatic logic [14:0] trigger_to_q15(logic [7:0] raw, logic [7:0] thr);
        int unsigned v;
        int unsigned t;
        v = raw;
        t = thr;
        if (v <= t) return '0;
        return rescale_q15(v - t, 32'd255 - t);
    endfunction

    function automatic t_pad_result condition_poll();
        t_pad_result r;
        logic [17:0] now;
        r = '0;
        if (!i_connected_in) return r;
        r.connected = 1'b1;
        r.trig_l    = trigger_to_q15(i_trigger_left_raw, trig_thr);
        r.trig_r    = trigger_to_q15(i_trigger_right_raw, trig_thr);
        now         = {r.trig_r != 0, r.trig_l != 0, i_buttons_raw};
        r.held      = now;
        r.pressed   = now & ~held_prev;
        r.released  = held_prev & ~now;
        r.lx        = stick_to_q15(i_stick_left_x, left_dz);
        r.ly        = stick_to_q15(i_stick_left_y, left_dz);
        r.rx        = stick_to_q15(i_stick_right_x, right_dz);
        r.ry        = stick_to_q15(i_stick_right_y, right_dz);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_pad_result want;
        t_pad_result fresh;
        if (!i_rst_n) begin
            left_dz   = LEFT_DZ_RST;
            right_dz  = RIGHT_DZ_RST;
            trig_thr  = TRIG_THR_RST;
            held_prev = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, got held %h",
                             $time, i_buttons_held);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("connected_out", want.connected, i_connected_out);
                    check_field("buttons_held", want.held, i_buttons_held);
                    check_field("buttons_pressed", want.pressed, i_buttons_pressed);
                    check_field("buttons_released", want.released, i_buttons_released);
                    check_field("trigger_left_norm", want.trig_l, i_trigger_left_norm);
                    check_field("trigger_right_norm", want.trig_r, i_trigger_right_norm);
                    check_field("left_x_norm", $signed(want.lx), $signed(i_left_x_norm));
                    check_field("left_y_norm", $signed(want.ly), $signed(i_left_y_norm));
                    check_field("right_x_norm", $signed(want.rx), $signed(i_right_x_norm));
                    check_field("right_y_norm", $signed(want.ry), $signed(i_right_y_norm));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = condition_poll();
                // a disconnected poll holds a zero mask, which clears the history
                held_prev = fresh.held;
                expected_results.push_back(fresh);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT_DZ:  left_dz  = i_cfg_data;
                    CFG_RIGHT_DZ: right_dz = i_cfg_data;
                    CFG_TRIG_THR: trig_thr = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        waiting = expected_results.size();
    end

endmodule

// File: tb/sv/gamepad_deadzone_edge_conditioner_core_test.sv
// ---------------------------------------------------------------------------
// Gamepad deadzone conditioner testbench
// Drives directed and random pad polls under several register settings,
// with random idling on both channels, a long output hold-off and full
// drains; a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module gamepad_deadzone_edge_conditioner_core_test;
    import gdec_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int PHASE_POLLS    = 135;
    localparam int HOLD_OFF_LEN   = 600;

    typedef struct packed {
        logic        connected;
        logic [15:0] buttons;
        logic [7:0]  trig_l;
        logic [7:0]  trig_r;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
    } t_pad_poll;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [14:0]           i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_connected_in;
    logic [15:0]           i_buttons_raw;
    logic [7:0]            i_trigger_left_raw;
    logic [7:0]            i_trigger_right_raw;
    logic signed [15:0]    i_stick_left_x;
    logic signed [15:0]    i_stick_left_y;
    logic signed [15:0]    i_stick_right_x;
    logic signed [15:0]    i_stick_right_y;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_connected_out;
    logic [17:0]           o_buttons_held;
    logic [17:0]           o_buttons_pressed;
    logic [17:0]           o_buttons_released;
    logic [14:0]           o_trigger_left_norm;
    logic [14:0]           o_trigger_right_norm;
    logic signed [15:0]    o_left_x_norm;
    logic signed [15:0]    o_left_y_norm;
    logic signed [15:0]    o_right_x_norm;
    logic signed [15:0]    o_right_y_norm;

    int mismatch_count;
    int pending_results;

    int feed_idle_pct   = 25;
    int drain_stall_pct = 25;
    logic hold_off_req  = 1'b0;

    int cur_left_dz  = LEFT_DZ_RST;
    int cur_right_dz = RIGHT_DZ_RST;
    int cur_thr      = TRIG_THR_RST;
    logic [15:0] last_buttons = '0;

    gamepad_deadzone_edge_conditioner_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_connected_in       (i_connected_in),
        .i_buttons_raw        (i_buttons_raw),
        .i_trigger_left_raw   (i_trigger_left_raw),
        .i_trigger_right_raw  (i_trigger_right_raw),
        .i_stick_left_x       (i_stick_left_x),
        .i_stick_left_y       (i_stick_left_y),
        .i_stick_right_x      (i_stick_right_x),
        .i_stick_right_y      (i_stick_right_y),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_connected_out      (o_connected_out),
        .o_buttons_held       (o_buttons_held),
        .o_buttons_pressed    (o_buttons_pressed),
        .o_buttons_released   (o_buttons_released),
        .o_trigger_left_norm  (o_trigger_left_norm),
        .o_trigger_right_norm (o_trigger_right_norm),
        .o_left_x_norm        (o_left_x_norm),
        .o_left_y_norm        (o_left_y_norm),
        .o_right_x_norm       (o_right_x_norm),
        .o_right_y_norm       (o_right_y_norm)
    );

    gdec_poll_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_connected_in       (i_connected_in),
        .i_buttons_raw        (i_buttons_raw),
        .i_trigger_left_raw   (i_trigger_left_raw),
        .i_trigger_right_raw  (i_trigger_right_raw),
        .i_stick_left_x       (i_stick_left_x),
        .i_stick_left_y       (i_stick_left_y),
        .i_stick_right_x      (i_stick_right_x),
        .i_stick_right_y      (i_stick_right_y),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_connected_out      (o_connected_out),
        .i_buttons_held       (o_buttons_held),
        .i_buttons_pressed    (o_buttons_pressed),
        .i_buttons_released   (o_buttons_released),
        .i_trigger_left_norm  (o_trigger_left_norm),
        .i_trigger_right_norm (o_trigger_right_norm),
        .i_left_x_norm        (o_left_x_norm),
        .i_left_y_norm        (o_left_y_norm),
        .i_right_x_norm       (o_right_x_norm),
        .i_right_y_norm       (o_right_y_norm),
        .o_mismatch_count     (mismatch_count),
        .o_pending            (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_stall
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < drain_stall_pct);
            end
        end
    end

    // called at a falling edge; returns at a falling edge with valid left high
    task automatic send_poll(input t_pad_poll p);
        while ($urandom_range(99) < feed_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_connected_in      <= p.connected;
        i_buttons_raw       <= p.buttons;
        i_trigger_left_raw  <= p.trig_l;
        i_trigger_right_raw <= p.trig_r;
        i_stick_left_x      <= p.lx;
        i_stick_left_y      <= p.ly;
        i_stick_right_x     <= p.rx;
        i_stick_right_y     <= p.ry;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and wait until every expected result has come
    task automatic drain_polls();
        i_in_valid <= 1'b0;
        wait (pending_results == 0);
        @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic set_config(input int left_dz, input int right_dz, input logic [14:0] thr_word);
        drain_polls();
        write_reg(CFG_LEFT_DZ, 15'(left_dz));
        write_reg(CFG_RIGHT_DZ, 15'(right_dz));
        write_reg(CFG_TRIG_THR, thr_word);
        i_cfg_we     <= 1'b0;
        cur_left_dz  = left_dz;
        cur_right_dz = right_dz;
        cur_thr      = thr_word[7:0];
    endtask

    function automatic logic [7:0] pick_trigger();
        int v;
        case ($urandom_range(3))
            0: v = cur_thr + $urandom_range(4) - 2;
            1: v = $urandom_range(1) ? 255 : 0;
            default: v = $urandom_range(255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic logic [15:0] pick_axis(input int dz);
        int m;
        case ($urandom_range(5))
            0, 1: return 16'($urandom);
            2: m = dz + $urandom_range(4) - 2;
            3: m = $urandom_range(dz);
            4: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h8001;
                    default: return 16'h0000;
                endcase
            end
            default: m = $urandom_range(32767, dz);
        endcase
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
        return $urandom_range(1) ? 16'(-m) : 16'(m);
    endfunction

    function automatic t_pad_poll random_poll();
        t_pad_poll p;
        p.connected = ($urandom_range(99) < 92);
        // half the time the held mask stays or flips at most two bits, so edges stay sparse
        case ($urandom_range(9))
            0: p.buttons = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2: p.buttons = last_buttons;
            3, 4, 5: p.buttons = last_buttons ^ (16'd1 << $urandom_range(15))
                                              ^ (16'd1 << $urandom_range(15));
            default: p.buttons = 16'($urandom);
        endcase
        last_buttons = p.buttons;
        p.trig_l = pick_trigger();
        p.trig_r = pick_trigger();
        p.lx     = pick_axis(cur_left_dz);
        p.ly     = pick_axis(cur_left_dz);
        p.rx     = pick_axis(cur_right_dz);
        p.ry     = pick_axis(cur_right_dz);
        return p;
    endfunction

    initial begin : stimulus
        int thr;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_LEFT_DZ;
        i_cfg_data          = '0;
        i_in_valid          = 1'b0;
        i_connected_in      = 1'b0;
        i_buttons_raw       = '0;
        i_trigger_left_raw  = '0;
        i_trigger_right_raw = '0;
        i_stick_left_x      = '0;
        i_stick_left_y      = '0;
        i_stick_right_x     = '0;
        i_stick_right_y     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default settings: extremes, deadzone and threshold edges, disconnects
        send_poll('{1'b0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_poll('{1'b1, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_poll('{1'b1, 16'h0000, 8'd30, 8'd31, 16'd7849, -16'sd7849, 16'd8689,
                    -16'sd8690});
        send_poll('{1'b1, 16'hA5A5, 8'd31, 8'd30, 16'd7850, -16'sd7850, 16'd8690,
                    16'h8001});
        send_poll('{1'b1, 16'h5A5A, 8'd0, 8'd255, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFE});
        send_poll('{1'b0, 16'h1234, 8'd200, 8'd100, 16'h4000, 16'hC000, 16'h2000, 16'hE000});
        send_poll('{1'b1, 16'h5A5A, 8'd128, 8'd29, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});

        // full deadzones: only the most negative axis gets through
        set_config(32767, 32767, 15'd255);
        send_poll('{1'b1, 16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h7FFF, 16'h8000, 16'h8001});

        // no deadzone: the most negative axis saturates
        set_config(0, 0, 15'd0);
        send_poll('{1'b1, 16'h0000, 8'd1, 8'd255, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF});
        send_poll('{1'b1, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000});

        // an unused register index changes nothing
        drain_polls();
        write_reg(CFG_IDX_SPARE, 15'h7FFF);
        i_cfg_we <= 1'b0;
        send_poll('{1'b1, 16'h8001, 8'd2, 8'd254, 16'h8001, 16'h0002, 16'hFFFE, 16'h7FFF});

        for (int ph = 0; ph < 8; ph++) begin
            thr = $urandom_range(255);
            case (ph)
                0: set_config(LEFT_DZ_RST, RIGHT_DZ_RST, {7'd0, TRIG_THR_RST});
                1: set_config(0, 0, 15'd0);
                2: set_config(32767, 32767, 15'd255);
                default: set_config($urandom_range(32767), $urandom_range(32767),
                                    {7'($urandom), 8'(thr)});
            endcase
            feed_idle_pct   = (ph == 3) ? 0 : 25;
            drain_stall_pct = (ph == 3) ? 0 : 25;
            if (ph == 4) hold_off_req = 1'b1;
            if (ph == 5) begin
                @(negedge i_clk);
                write_reg(CFG_IDX_SPARE, 15'($urandom));
                i_cfg_we <= 1'b0;
            end
            repeat (PHASE_POLLS) send_poll(random_poll());
        end

        drain_polls();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
